// ----- hw/rtl/sawr_pkg.sv -----
// Shared types and constants for the stop-and-wait acknowledgment receiver.
// No dependencies; imported by sawr_parser, stop_and_wait_ack_receiver, ack_link_checker and the testbench.
package sawr_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_SEND = 2'd1,
        EV_ACK  = 2'd2,
        EV_FAIL = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        P_START   = 3'd0,
        P_FLAG    = 3'd1,
        P_ADDR    = 3'd2,
        P_C_RR    = 3'd3,
        P_C_REJ   = 3'd4,
        P_BCC_RR  = 3'd5,
        P_BCC_REJ = 3'd6,
        P_STOP    = 3'd7
    } parse_state_t;

    typedef enum logic [1:0] {
        CFG_FLAG_BYTE   = 2'd0,
        CFG_REPLY_ADDR  = 2'd1,
        CFG_MAX_RETRANS = 2'd2,
        CFG_TIMEOUT     = 2'd3
    } cfg_index_t;

    // Control codes, selected by the current sequence bit
    localparam logic [7:0] RR_SEQ1  = 8'h05;
    localparam logic [7:0] REJ_SEQ1 = 8'h01;
    localparam logic [7:0] RR_SEQ0  = 8'h85;
    localparam logic [7:0] REJ_SEQ0 = 8'h81;

    localparam logic [7:0]  FLAG_RESET    = 8'h7E;
    localparam logic [7:0]  ADDR_RESET    = 8'h01;
    localparam logic [7:0]  MAX_RT_RESET  = 8'd3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3;
    localparam logic [7:0]  RETRY_MAX     = 8'hFF;

endpackage

// ----- hw/rtl/stop_and_wait_ack_receiver.sv -----
// Stop-and-wait link, transmitter acknowledgment side: start, received-byte and
// tick transactions in, one event transaction out per input. Uses sawr_pkg, sawr_parser.
//
// Every input transaction yields exactly one output transaction. A transaction
// is taken into an input register, processed combinationally against the link
// state, and its result lands in an output register: one transaction per cycle
// while the output is not stalled. The input register keeps taking transactions
// while a result waits, and only stalls when both registers are full and the output
// is stalled. The user must write configuration (flag, address, retry limit, timeout)
// through cfg_we/cfg_index/cfg_data while the block is idle; the block does not check.
module stop_and_wait_ack_receiver
    import sawr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic        sequence_bit,
    output logic        busy_res
);

    // configuration
    logic [7:0]   flag_byte_reg;
    logic [7:0]   reply_address_reg;
    logic [7:0]   max_retrans_reg;
    logic [15:0]  timeout_ticks_reg;

    // link state
    parse_state_t parser_state_reg, parser_state_next;
    logic         seq_bit_reg, seq_bit_next;
    logic [7:0]   retry_count_reg, retry_count_next;
    logic [15:0]  ticks_left_reg, ticks_left_next;
    logic         waiting_reg, waiting_next;

    // input and output registers
    logic         s1_valid_reg, s1_valid_next;
    opcode_t      s1_opcode_reg;
    logic [7:0]   s1_byte_reg;
    logic         out_valid_reg, out_valid_next;
    event_t       event_reg, event_next;
    logic         seq_out_reg;
    logic         busy_out_reg;

    logic         in_accept;
    logic         proc;
    parse_state_t parsed_state;
    logic [7:0]   retry_inc;

    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign proc      = s1_valid_reg && !(out_valid_reg && out_stall);

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign sequence_bit = seq_out_reg;
    assign busy_res     = busy_out_reg;

    sawr_parser u_parser (
        .state         (parser_state_reg),
        .rx_byte       (s1_byte_reg),
        .seq_bit       (seq_bit_reg),
        .flag_byte     (flag_byte_reg),
        .reply_address (reply_address_reg),
        .state_next    (parsed_state)
    );

    assign retry_inc = (retry_count_reg == RETRY_MAX) ? RETRY_MAX : retry_count_reg + 8'd1;

    always_comb
    begin
        parser_state_next = parser_state_reg;
        seq_bit_next      = seq_bit_reg;
        retry_count_next  = retry_count_reg;
        ticks_left_next   = ticks_left_reg;
        waiting_next      = waiting_reg;
        event_next        = EV_NONE;

        if (proc)
        begin
            unique case (s1_opcode_reg)
                OP_START:
                begin
                    retry_count_next = '0;
                    if (max_retrans_reg == '0)
                    begin
                        waiting_next      = 1'b0;
                        parser_state_next = P_START;
                        event_next        = EV_FAIL;
                    end
                    else
                    begin
                        ticks_left_next   = timeout_ticks_reg;
                        parser_state_next = P_START;
                        waiting_next      = 1'b1;
                        event_next        = EV_SEND;
                    end
                end
                OP_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        if (parsed_state == P_STOP)
                        begin
                            parser_state_next = P_START;
                            waiting_next      = 1'b0;
                            seq_bit_next      = !seq_bit_reg;
                            event_next        = EV_ACK;
                        end
                        else
                        begin
                            parser_state_next = parsed_state;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (waiting_reg)
                    begin
                        if (ticks_left_reg > 16'd1)
                        begin
                            ticks_left_next = ticks_left_reg - 16'd1;
                        end
                        else
                        begin
                            // expiry; a zero timeout expires on the first tick
                            ticks_left_next  = '0;
                            retry_count_next = retry_inc;
                            if (retry_inc >= max_retrans_reg)
                            begin
                                waiting_next      = 1'b0;
                                parser_state_next = P_START;
                                event_next        = EV_FAIL;
                            end
                            else
                            begin
                                ticks_left_next   = timeout_ticks_reg;
                                parser_state_next = P_START;
                                waiting_next      = 1'b1;
                                event_next        = EV_SEND;
                            end
                        end
                    end
                end
                default:
                begin
                    event_next = EV_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (proc)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        if (proc)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_byte_reg     <= FLAG_RESET;
            reply_address_reg <= ADDR_RESET;
            max_retrans_reg   <= MAX_RT_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
            parser_state_reg  <= P_START;
            seq_bit_reg       <= 1'b0;
            retry_count_reg   <= '0;
            ticks_left_reg    <= '0;
            waiting_reg       <= 1'b0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FLAG_BYTE:   flag_byte_reg     <= cfg_data[7:0];
                    CFG_REPLY_ADDR:  reply_address_reg <= cfg_data[7:0];
                    CFG_MAX_RETRANS: max_retrans_reg   <= cfg_data[7:0];
                    CFG_TIMEOUT:     timeout_ticks_reg <= cfg_data;
                    default:         flag_byte_reg     <= flag_byte_reg;
                endcase
            end
            parser_state_reg <= parser_state_next;
            seq_bit_reg      <= seq_bit_next;
            retry_count_reg  <= retry_count_next;
            ticks_left_reg   <= ticks_left_next;
            waiting_reg      <= waiting_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg <= opcode_t'(opcode);
            s1_byte_reg   <= rx_byte;
        end
        if (proc)
        begin
            event_reg    <= event_next;
            seq_out_reg  <= seq_bit_next;
            busy_out_reg <= waiting_next;
        end
    end

    // assertions
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free register");

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (event_reg == EV_SEND) |-> busy_out_reg)
        else $error("send event without busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((event_reg == EV_ACK) || (event_reg == EV_FAIL)) |-> !busy_out_reg)
        else $error("ack or fail event while busy");

    a_seq_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_bit_reg != $past(seq_bit_reg)) |-> out_valid_reg && (event_reg == EV_ACK))
        else $error("sequence bit changed without acknowledgment");

endmodule

// ----- hw/rtl/sawr_parser.sv -----
// Reply frame recognizer: next parser state for one received byte.
// Depends on sawr_pkg.
module sawr_parser
    import sawr_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   rx_byte,
    input  logic         seq_bit,
    input  logic [7:0]   flag_byte,
    input  logic [7:0]   reply_address,
    output parse_state_t state_next
);

    logic [7:0] rr_code;
    logic [7:0] rej_code;
    logic       is_flag;

    assign rr_code  = seq_bit ? RR_SEQ1 : RR_SEQ0;
    assign rej_code = seq_bit ? REJ_SEQ1 : REJ_SEQ0;
    assign is_flag  = (rx_byte == flag_byte);

    always_comb
    begin
        state_next = P_START;
        unique case (state)
            P_START:
            begin
                state_next = is_flag ? P_FLAG : P_START;
            end
            P_FLAG:
            begin
                if (is_flag)
                    state_next = P_FLAG;
                else if (rx_byte == reply_address)
                    state_next = P_ADDR;
            end
            P_ADDR:
            begin
                if (is_flag)
                    state_next = P_FLAG;
                else if (rx_byte == rr_code)
                    state_next = P_C_RR;
                else if (rx_byte == rej_code)
                    state_next = P_C_REJ;
            end
            P_C_RR:
            begin
                if (is_flag)
                    state_next = P_FLAG;
                else if (rx_byte == (reply_address ^ rr_code))
                    state_next = P_BCC_RR;
            end
            P_C_REJ:
            begin
                if (is_flag)
                    state_next = P_FLAG;
                else if (rx_byte == (reply_address ^ rej_code))
                    state_next = P_BCC_REJ;
            end
            P_BCC_RR:
            begin
                state_next = is_flag ? P_STOP : P_START;
            end
            // reject check byte: anything after it, flag included, restarts
            P_BCC_REJ:
            begin
                state_next = P_START;
            end
            P_STOP:
            begin
                state_next = P_STOP;
            end
            default:
            begin
                state_next = P_START;
            end
        endcase
    end

endmodule

// ----- bench/ack_link_checker.sv -----
// Checker for the stop-and-wait acknowledgment receiver: watches the config port and both
// channels, predicts each event transaction and compares it field by field.
// Depends on sawr_pkg for the opcode, event, parser-state and config-index types and constants.
module ack_link_checker
    import sawr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  event_res,
    input  logic        sequence_bit,
    input  logic        busy_res,
    output int          fail_count,
    output int          pending,
    output logic        link_seq
);

    typedef struct packed {
        event_t ev;
        logic   seq;
        logic   busy;
    } link_result_t;

    // shadow registers
    logic [7:0]  flag_val;
    logic [7:0]  addr_val;
    logic [7:0]  retry_limit;
    logic [15:0] timeout_val;

    // predicted link state
    parse_state_t rx_state;
    logic         seq_q;
    logic [7:0]   retries;
    logic [15:0]  ticks_left;
    logic         awaiting_ack;

    link_result_t expected_events[$];
    link_result_t want;

    assign link_seq = seq_q;

    function automatic parse_state_t next_rx_state(parse_state_t st, logic [7:0] b);
        logic [7:0] rr;
        logic [7:0] rej;
        rr  = seq_q ? RR_SEQ1 : RR_SEQ0;
        rej = seq_q ? REJ_SEQ1 : REJ_SEQ0;
        case (st)
            P_START:
                if (b == flag_val) return P_FLAG;
            P_FLAG:
            begin
                if (b == flag_val) return P_FLAG;
                if (b == addr_val) return P_ADDR;
            end
            P_ADDR:
            begin
                if (b == flag_val) return P_FLAG;
                if (b == rr) return P_C_RR;
                if (b == rej) return P_C_REJ;
            end
            P_C_RR:
            begin
                if (b == flag_val) return P_FLAG;
                if (b == (addr_val ^ rr)) return P_BCC_RR;
            end
            P_C_REJ:
            begin
                if (b == flag_val) return P_FLAG;
                if (b == (addr_val ^ rej)) return P_BCC_REJ;
            end
            P_BCC_RR:
                if (b == flag_val) return P_STOP;
            P_BCC_REJ: ;
            default:
                return st;
        endcase
        return P_START;
    endfunction

    function automatic void arm_timer();
        ticks_left   = timeout_val;
        rx_state     = P_START;
        awaiting_ack = 1'b1;
    endfunction

    function automatic link_result_t step_link(logic [1:0] op, logic [7:0] b);
        link_result_t r;
        r.ev = EV_NONE;
        case (op)
            OP_START:
            begin
                retries = '0;
                if (retry_limit == 8'd0)
                begin
                    awaiting_ack = 1'b0;
                    rx_state     = P_START;
                    r.ev         = EV_FAIL;
                end
                else
                begin
                    arm_timer();
                    r.ev = EV_SEND;
                end
            end
            OP_BYTE:
                if (awaiting_ack)
                begin
                    rx_state = next_rx_state(rx_state, b);
                    if (rx_state == P_STOP)
                    begin
                        rx_state     = P_START;
                        awaiting_ack = 1'b0;
                        seq_q        = ~seq_q;
                        r.ev         = EV_ACK;
                    end
                end
            OP_TICK:
                if (awaiting_ack)
                begin
                    // a timeout of zero expires on the first tick, same as one
                    if (ticks_left > 16'd1)
                        ticks_left = ticks_left - 16'd1;
                    else
                    begin
                        ticks_left = '0;
                        if (retries != RETRY_MAX)
                            retries = retries + 8'd1;
                        if (retries >= retry_limit)
                        begin
                            awaiting_ack = 1'b0;
                            rx_state     = P_START;
                            r.ev         = EV_FAIL;
                        end
                        else
                        begin
                            arm_timer();
                            r.ev = EV_SEND;
                        end
                    end
                end
            default: ;
        endcase
        r.seq  = seq_q;
        r.busy = awaiting_ack;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_val     = FLAG_RESET;
            addr_val     = ADDR_RESET;
            retry_limit  = MAX_RT_RESET;
            timeout_val  = TIMEOUT_RESET;
            rx_state     = P_START;
            seq_q        = 1'b0;
            retries      = '0;
            ticks_left   = '0;
            awaiting_ack = 1'b0;
            expected_events.delete();
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_FLAG_BYTE:   flag_val    = cfg_data[7:0];
                    CFG_REPLY_ADDR:  addr_val    = cfg_data[7:0];
                    CFG_MAX_RETRANS: retry_limit = cfg_data[7:0];
                    CFG_TIMEOUT:     timeout_val = cfg_data;
                    default: ;
                endcase

            // retire before predicting so a stray result is never matched to a new item
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected result transaction: event_res %0d", event_res);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_res !== want.ev)
                    begin
                        $error("event_res expected %0d got %0d", want.ev, event_res);
                        fail_count++;
                    end
                    if (sequence_bit !== want.seq)
                    begin
                        $error("sequence_bit expected %0d got %0d", want.seq, sequence_bit);
                        fail_count++;
                    end
                    if (busy_res !== want.busy)
                    begin
                        $error("busy_res expected %0d got %0d", want.busy, busy_res);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
                expected_events.push_back(step_link(opcode, rx_byte));

            pending <= expected_events.size();
        end
    end

endmodule

// ----- bench/stop_and_wait_ack_receiver_tb.sv -----
// Testbench top for stop_and_wait_ack_receiver: clock, reset, configuration phases,
// directed and random transactions on both channels. Checking lives in ack_link_checker.
// Depends on sawr_pkg and the block's RTL.
module stop_and_wait_ack_receiver_tb;
    import sawr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  event_res;
    logic        sequence_bit;
    logic        busy_res;

    int   fail_count;
    int   pending;
    logic link_seq;

    // current register values, used to build well-formed replies and to bound safe ticks
    logic [7:0]  cur_flag;
    logic [7:0]  cur_addr;
    logic [15:0] cur_tmo;

    int items_sent;
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_cycles;

    stop_and_wait_ack_receiver uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .sequence_bit(sequence_bit),
        .busy_res    (busy_res)
    );

    ack_link_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .sequence_bit(sequence_bit),
        .busy_res    (busy_res),
        .fail_count  (fail_count),
        .pending     (pending),
        .link_seq    (link_seq)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2000000;
        $display("stop_and_wait_ack_receiver regression: fail");
        $finish;
    end

    // result side: random stall per transaction, plus an occasional long hold-off
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
            begin
                gap = rx_idle_on ? $urandom_range(0, 4) : 0;
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // called at a clock edge; returns at the edge where the transaction is taken,
    // with valid still high so back-to-back transactions need no extra edge
    task automatic push_item(logic [1:0] op, logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_item(OP_TICK, 8'($urandom));
    endtask

    // flag, address, control, check, flag; bad_pos < 0 leaves the frame intact
    task automatic send_reply(bit reject, int bad_pos);
        logic [7:0] b;
        logic [7:0] ctrl;
        ctrl = '0;
        for (int i = 0; i < 5; i++)
        begin
            case (i)
                1: b = cur_addr;
                2:
                begin
                    // earlier frame bytes are already taken, so the sequence bit is settled
                    if (reject)
                        ctrl = link_seq ? REJ_SEQ1 : REJ_SEQ0;
                    else
                        ctrl = link_seq ? RR_SEQ1 : RR_SEQ0;
                    b = ctrl;
                end
                3: b = cur_addr ^ ctrl;
                default: b = cur_flag;
            endcase
            if (i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            push_item(OP_BYTE, b);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure_link(logic [7:0] flag, logic [7:0] addr, logic [7:0] limit,
                                  logic [15:0] tmo);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        write_reg(CFG_FLAG_BYTE, {8'h00, flag});
        write_reg(CFG_REPLY_ADDR, {8'h00, addr});
        write_reg(CFG_MAX_RETRANS, {8'h00, limit});
        write_reg(CFG_TIMEOUT, tmo);
        cfg_we    <= 1'b0;
        cur_flag  = flag;
        cur_addr  = addr;
        cur_tmo   = tmo;
    endtask

    task automatic run_traffic(int quota);
        int goal;
        int pick;
        int safe;
        goal = items_sent + quota;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            // ticks that keep the timer from expiring before the reply lands
            safe = (cur_tmo > 16'd1) ? ((cur_tmo > 16'd3) ? 2 : int'(cur_tmo) - 1) : 0;
            if (pick < 45)
            begin
                push_item(OP_START, 8'($urandom));
                push_ticks($urandom_range(0, safe));
                if ($urandom_range(0, 3) == 0)
                    push_item(OP_BYTE, cur_flag);
                send_reply(1'b0, -1);
            end
            else if (pick < 55)
            begin
                push_item(OP_START, 8'($urandom));
                send_reply(1'b1, -1);
                send_reply(1'b0, -1);
            end
            else if (pick < 68)
            begin
                push_item(OP_START, 8'($urandom));
                send_reply(1'b0, $urandom_range(0, 4));
            end
            else if (pick < 80)
            begin
                push_item(OP_START, 8'($urandom));
                push_ticks($urandom_range(1, 12));
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6))
                    push_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
            else
            begin
                // start while busy
                push_item(OP_START, 8'($urandom));
                push_item(OP_START, 8'($urandom));
                send_reply(1'b0, -1);
            end
        end
    endtask

    initial
    begin
        logic [7:0] f;
        logic [7:0] a;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_FLAG_BYTE;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        opcode     <= OP_START;
        rx_byte    <= '0;
        items_sent  = 0;
        hold_cycles = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        cur_flag    = FLAG_RESET;
        cur_addr    = ADDR_RESET;
        cur_tmo     = TIMEOUT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_UNUSED, 8'hFF);
        push_item(OP_START, 8'h00);
        send_reply(1'b0, -1);
        push_item(OP_START, 8'hFF);
        send_reply(1'b1, -1);
        push_item(OP_START, 8'h55);
        push_item(OP_BYTE, 8'hFF);
        push_ticks(9);

        configure_link(8'h00, 8'hFF, 8'd1, 16'd1);
        run_traffic(125);

        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        configure_link(8'hFF, 8'h00, 8'd255, 16'd65535);
        hold_cycles = 300;
        run_traffic(125);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        f = 8'($urandom);
        do a = 8'($urandom); while (a == f);
        configure_link(f, a, 8'd0, 16'd2);
        run_traffic(25);

        tx_idle_on = 1'b1;
        configure_link(8'h7E, 8'h03, 8'd2, 16'd0);
        run_traffic(125);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        f = 8'($urandom);
        do a = 8'($urandom); while (a == f);
        configure_link(f, a, 8'($urandom_range(3, 6)), 16'($urandom_range(3, 5)));
        run_traffic(125);

        tx_idle_on = 1'b1;
        configure_link(FLAG_RESET, ADDR_RESET, MAX_RT_RESET, TIMEOUT_RESET);
        run_traffic(125);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("stop_and_wait_ack_receiver regression: pass");
        else
            $display("stop_and_wait_ack_receiver regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sawr_pkg.sv
hw/rtl/sawr_parser.sv
hw/rtl/stop_and_wait_ack_receiver.sv
bench/ack_link_checker.sv
bench/stop_and_wait_ack_receiver_tb.sv
